@@ hdl/sparse_row_block_mask_encoder_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sparse row block mask encoder
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef SPARSE_ROW_BLOCK_MASK_ENCODER_UNIT_ASSERT_SVH
`define SPARSE_ROW_BLOCK_MASK_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication
`define SRBME_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define SRBME_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hdl/srbme_pkg.sv @@
// ---------------------------------------------------------------------------
// srbme_pkg
// Types and constants shared by the sparse row block mask encoder modules.
// ---------------------------------------------------------------------------
package srbme_pkg;

    // input item modes
    typedef enum logic [1:0] {
        MODE_LOAD       = 2'd0,
        MODE_ENTRY      = 2'd1,
        MODE_ROW_END    = 2'd2,
        MODE_STREAM_END = 2'd3
    } mode_t;

    // result item kinds
    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_ROW_END = 2'd1,
        KIND_TOTALS  = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_RANGE = 2'd0,
        ERR_WIDTH = 2'd1,
        ERR_ORDER = 2'd2
    } err_code_t;

    // classified operations handed from front to back
    typedef enum logic [1:0] {
        OP_ENTRY      = 2'd0,
        OP_ERROR      = 2'd1,
        OP_ROW_END    = 2'd2,
        OP_STREAM_END = 2'd3
    } op_t;

    localparam int BLK_W   = 10;
    localparam int LOC_W   = 5;
    localparam int WID_W   = 6;
    localparam int CNT_W   = 32;
    localparam int BCNT_W  = 11;
    localparam int KEY_W   = BLK_W + LOC_W;

    // APB map: one register at byte 0, paddr[2] selects register index
    localparam int         APB_AW          = 3;
    localparam logic [0:0] REG_BLOCK_COUNT = 1'b0;
    localparam logic [BCNT_W-1:0] BLOCK_COUNT_RESET = 11'd1;

    // command queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [BLK_W-1:0] block_id;
        logic [LOC_W-1:0] local_id;
        logic [WID_W-1:0] tbl_width;
    } in_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [BLK_W-1:0] rec_block;
        logic [31:0]      gene_mask;
        logic [31:0]      value_offset;
        logic [31:0]      record_index;
        logic [1:0]       error_code;
        logic             error_seen;
        logic             last;
    } out_t;

    typedef struct packed {
        op_t              op;
        err_code_t        ecode;
        logic [BLK_W-1:0] blk;
        logic [LOC_W-1:0] loc;
    } cmd_t;

endpackage

@@ hdl/srbme_front.sv @@
// ---------------------------------------------------------------------------
// srbme_front
// Accepts items, holds the block width table, checks entries and pushes
// classified commands into the queue.
// ---------------------------------------------------------------------------
module srbme_front #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MASK_BITS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  srbme_pkg::in_t               s_data,
    input  logic [srbme_pkg::BCNT_W-1:0] block_count,
    output logic                         q_push,
    output srbme_pkg::cmd_t              q_cmd,
    input  logic                         q_full
);

    localparam int TAB_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [srbme_pkg::WID_W-1:0] width_mem [MAX_BLOCKS];
    logic [srbme_pkg::WID_W-1:0] rd_width_reg;
    srbme_pkg::in_t              a_item_reg;
    logic                        a_valid_reg, a_valid_next;
    logic                        prior_valid_reg, prior_valid_next;
    logic [srbme_pkg::KEY_W-1:0] prior_key_reg, prior_key_next;

    logic                        accept;
    logic [TAB_AW-1:0]           tab_idx;
    logic                        tab_wr_ok;
    logic [srbme_pkg::KEY_W-1:0] key;
    logic                        blk_bad, loc_bad, ord_bad;

    assign accept    = s_valid && s_ready;
    assign tab_idx   = TAB_AW'(s_data.block_id);
    assign tab_wr_ok = 32'(s_data.block_id) < 32'(MAX_BLOCKS);

    // stage A advances once its command is in the queue
    assign q_push  = a_valid_reg && !q_full;
    assign s_ready = !a_valid_reg || !q_full;

    // table port: one write (load), one registered read per item
    always_ff @(posedge aclk) begin
        if (accept && s_data.mode == srbme_pkg::MODE_LOAD && tab_wr_ok) begin
            width_mem[tab_idx] <= s_data.tbl_width;
        end
        if (accept) begin
            rd_width_reg <= width_mem[tab_idx];
            a_item_reg   <= s_data;
        end
    end

    assign key     = {a_item_reg.block_id, a_item_reg.local_id};
    assign blk_bad = ({1'b0, a_item_reg.block_id} >= block_count)
                     || (32'(a_item_reg.block_id) >= 32'(MAX_BLOCKS));
    assign loc_bad = ({1'b0, a_item_reg.local_id} >= rd_width_reg)
                     || (32'(a_item_reg.local_id) >= 32'(MASK_BITS));
    assign ord_bad = prior_valid_reg && (key <= prior_key_reg);

    always_comb begin
        q_cmd.blk        = a_item_reg.block_id;
        q_cmd.loc        = a_item_reg.local_id;
        q_cmd.ecode      = srbme_pkg::ERR_RANGE;
        q_cmd.op         = srbme_pkg::OP_ENTRY;
        prior_valid_next = prior_valid_reg;
        prior_key_next   = prior_key_reg;
        unique case (a_item_reg.mode)
            srbme_pkg::MODE_ENTRY: begin
                priority if (blk_bad) begin
                    q_cmd.op    = srbme_pkg::OP_ERROR;
                    q_cmd.ecode = srbme_pkg::ERR_RANGE;
                end else if (loc_bad) begin
                    q_cmd.op    = srbme_pkg::OP_ERROR;
                    q_cmd.ecode = srbme_pkg::ERR_WIDTH;
                end else if (ord_bad) begin
                    q_cmd.op    = srbme_pkg::OP_ERROR;
                    q_cmd.ecode = srbme_pkg::ERR_ORDER;
                end else begin
                    prior_valid_next = 1'b1;
                    prior_key_next   = key;
                end
            end
            srbme_pkg::MODE_ROW_END: begin
                q_cmd.op         = srbme_pkg::OP_ROW_END;
                prior_valid_next = 1'b0;
                prior_key_next   = '0;
            end
            srbme_pkg::MODE_STREAM_END: begin
                q_cmd.op         = srbme_pkg::OP_STREAM_END;
                prior_valid_next = 1'b0;
                prior_key_next   = '0;
            end
            default: begin
                // loads never reach stage A
                q_cmd.op = srbme_pkg::OP_ENTRY;
            end
        endcase
    end

    always_comb begin
        a_valid_next = a_valid_reg && !q_push;
        if (accept) begin
            a_valid_next = (s_data.mode != srbme_pkg::MODE_LOAD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            prior_valid_reg <= 1'b0;
            prior_key_reg   <= '0;
        end else begin
            a_valid_reg <= a_valid_next;
            if (q_push) begin
                prior_valid_reg <= prior_valid_next;
                prior_key_reg   <= prior_key_next;
            end
        end
    end

endmodule

@@ hdl/srbme_fifo.sv @@
// ---------------------------------------------------------------------------
// srbme_fifo
// Short command queue between front and back.
// ---------------------------------------------------------------------------
`include "sparse_row_block_mask_encoder_unit_assert.svh"

module srbme_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  srbme_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output srbme_pkg::cmd_t head_cmd
);

    srbme_pkg::cmd_t           slot_reg [srbme_pkg::Q_DEPTH];
    logic [srbme_pkg::Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [srbme_pkg::Q_AW:0]   count_reg, count_next;

    assign full      = (count_reg == (srbme_pkg::Q_AW+1)'(srbme_pkg::Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `SRBME_ASSERT_NOW(a_no_overflow, aclk, aresetn, push, !full || pop)
    `SRBME_ASSERT_NOW(a_no_underflow, aclk, aresetn, pop, not_empty)
    `SRBME_ASSERT_NOW(a_ptr_gap, aclk, aresetn, 1'b1,
        (wr_ptr_reg - rd_ptr_reg) == count_reg[srbme_pkg::Q_AW-1:0])

endmodule

@@ hdl/srbme_back.sv @@
// ---------------------------------------------------------------------------
// srbme_back
// Executes queued commands: open record, counters, sticky error flag and
// the registered result output.
// ---------------------------------------------------------------------------
`include "sparse_row_block_mask_encoder_unit_assert.svh"

module srbme_back #(
    parameter int MASK_BITS = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_not_empty,
    input  srbme_pkg::cmd_t q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output srbme_pkg::out_t m_data
);

    localparam logic [srbme_pkg::CNT_W-1:0] CNT_MAX = '1;

    logic                         open_valid_reg, open_valid_next;
    logic [srbme_pkg::BLK_W-1:0]  open_block_reg, open_block_next;
    logic [MASK_BITS-1:0]         open_mask_reg, open_mask_next;
    logic [srbme_pkg::CNT_W-1:0]  open_start_reg, open_start_next;
    logic [srbme_pkg::CNT_W-1:0]  entry_total_reg, entry_total_next;
    logic [srbme_pkg::CNT_W-1:0]  record_total_reg, record_total_next;
    logic                         error_flag_reg, error_flag_next;
    logic                         m_valid_reg, m_valid_next;
    srbme_pkg::out_t              m_data_reg, m_data_next;

    logic                         step, emit, is_end;
    logic [srbme_pkg::CNT_W-1:0]  record_inc, entry_inc;
    logic [MASK_BITS-1:0]         loc_bit;
    srbme_pkg::out_t              rec_out;

    assign step   = q_not_empty && (!m_valid_reg || m_ready);
    assign is_end = (q_cmd.op == srbme_pkg::OP_ROW_END)
                    || (q_cmd.op == srbme_pkg::OP_STREAM_END);
    // an end command that closes a record stays for a second result
    assign q_pop  = step && !(is_end && open_valid_reg);

    assign record_inc = (record_total_reg == CNT_MAX) ? record_total_reg
                                                      : record_total_reg + 1'b1;
    assign entry_inc  = (entry_total_reg == CNT_MAX) ? entry_total_reg
                                                     : entry_total_reg + 1'b1;
    assign loc_bit    = MASK_BITS'(1) << q_cmd.loc;

    always_comb begin
        rec_out              = '0;
        rec_out.kind         = srbme_pkg::KIND_RECORD;
        rec_out.rec_block    = open_block_reg;
        rec_out.gene_mask    = 32'(open_mask_reg);
        rec_out.value_offset = open_start_reg;
        rec_out.record_index = record_total_reg;
        rec_out.error_seen   = error_flag_reg;
    end

    always_comb begin
        open_valid_next   = open_valid_reg;
        open_block_next   = open_block_reg;
        open_mask_next    = open_mask_reg;
        open_start_next   = open_start_reg;
        entry_total_next  = entry_total_reg;
        record_total_next = record_total_reg;
        error_flag_next   = error_flag_reg;
        emit              = 1'b0;
        m_data_next       = rec_out;
        if (step) begin
            unique case (q_cmd.op)
                srbme_pkg::OP_ENTRY: begin
                    if (open_valid_reg && open_block_reg == q_cmd.blk) begin
                        open_mask_next = open_mask_reg | loc_bit;
                    end else begin
                        if (open_valid_reg) begin
                            emit              = 1'b1;
                            m_data_next.last  = 1'b1;
                            record_total_next = record_inc;
                        end
                        open_block_next = q_cmd.blk;
                        open_mask_next  = loc_bit;
                        open_start_next = entry_total_reg;
                    end
                    open_valid_next  = 1'b1;
                    entry_total_next = entry_inc;
                end
                srbme_pkg::OP_ERROR: begin
                    emit                   = 1'b1;
                    error_flag_next        = 1'b1;
                    m_data_next            = '0;
                    m_data_next.kind       = srbme_pkg::KIND_ERROR;
                    m_data_next.rec_block  = q_cmd.blk;
                    m_data_next.error_code = q_cmd.ecode;
                    m_data_next.error_seen = 1'b1;
                    m_data_next.last       = 1'b1;
                end
                srbme_pkg::OP_ROW_END,
                srbme_pkg::OP_STREAM_END: begin
                    emit = 1'b1;
                    if (open_valid_reg) begin
                        // flush first, report on the next step
                        record_total_next = record_inc;
                        open_valid_next   = 1'b0;
                        open_mask_next    = '0;
                    end else begin
                        m_data_next              = '0;
                        m_data_next.record_index = record_total_reg;
                        m_data_next.error_seen   = error_flag_reg;
                        m_data_next.last         = 1'b1;
                        if (q_cmd.op == srbme_pkg::OP_ROW_END) begin
                            m_data_next.kind = srbme_pkg::KIND_ROW_END;
                        end else begin
                            m_data_next.kind         = srbme_pkg::KIND_TOTALS;
                            m_data_next.value_offset = entry_total_reg;
                            open_block_next          = '0;
                            open_mask_next           = '0;
                            open_start_next          = '0;
                            entry_total_next         = '0;
                            record_total_next        = '0;
                            error_flag_next          = 1'b0;
                        end
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (step) begin
            m_valid_next = emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            m_data_reg <= m_data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_valid_reg   <= 1'b0;
            open_block_reg   <= '0;
            open_mask_reg    <= '0;
            open_start_reg   <= '0;
            entry_total_reg  <= '0;
            record_total_reg <= '0;
            error_flag_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            open_valid_reg   <= open_valid_next;
            open_block_reg   <= open_block_next;
            open_mask_reg    <= open_mask_next;
            open_start_reg   <= open_start_next;
            entry_total_reg  <= entry_total_next;
            record_total_reg <= record_total_next;
            error_flag_reg   <= error_flag_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SRBME_ASSERT_NEXT(a_err_sticky, aclk, aresetn,
        step && q_cmd.op == srbme_pkg::OP_ERROR, error_flag_reg)
    `SRBME_ASSERT_NEXT(a_totals_clear, aclk, aresetn,
        q_pop && q_cmd.op == srbme_pkg::OP_STREAM_END,
        !error_flag_reg && entry_total_reg == '0 && record_total_reg == '0)
    `SRBME_ASSERT_NOW(a_flush_holds, aclk, aresetn,
        step && is_end && open_valid_reg, !q_pop)
    `SRBME_ASSERT_NOW(a_closed_mask_zero, aclk, aresetn,
        !open_valid_reg, open_mask_reg == '0)

endmodule

@@ hdl/sparse_row_block_mask_encoder_unit.sv @@
// ---------------------------------------------------------------------------
// sparse_row_block_mask_encoder_unit
// Groups a sparse row stream into block records with a local feature mask.
// ---------------------------------------------------------------------------
// Usage:
//   s_ channel takes one item per cycle while s_ready is high: a width-table
//   load, a data entry, an end of row or an end of stream. m_ channel returns
//   result items (record, row count, stream totals or entry error),
//   m_data.last on the final result of each item. Loads and entries that only
//   extend the open record give no result.
//   Path: the registered width-table read and the checks in stage A, the
//   command queue, then the record update into the output register.
//   Throughput: one item per cycle while the queue has room; an end of row
//   or stream that closes an open record gives two results, the record and
//   then the count or totals, and leaves the queue only after the second.
//   A stalled receiver holds the output register; the four-entry command
//   queue then fills and s_ready falls, so nothing is dropped.
//   Reset clears the open record, counters, error flag and queue and sets
//   block_count to 1. The width table is not cleared: load every block's
//   width before sending entries of that block. block_count is written over
//   APB at byte 0, by the user only while idle; the block has no check.
// ---------------------------------------------------------------------------
module sparse_row_block_mask_encoder_unit #(
    parameter int MAX_BLOCKS = 1024,
    parameter int MASK_BITS  = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input items
    input  logic                         s_valid,
    output logic                         s_ready,
    input  srbme_pkg::in_t               s_data,
    // result items
    output logic                         m_valid,
    input  logic                         m_ready,
    output srbme_pkg::out_t              m_data,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [srbme_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [srbme_pkg::BCNT_W-1:0] block_count_reg;
    logic                         cfg_wr;
    logic                         q_push, q_full, q_pop, q_not_empty;
    srbme_pkg::cmd_t              push_cmd, head_cmd;

    // register file: block_count only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[srbme_pkg::APB_AW-1:2] == srbme_pkg::REG_BLOCK_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= srbme_pkg::BLOCK_COUNT_RESET;
        end else if (cfg_wr) begin
            block_count_reg <= pwdata[srbme_pkg::BCNT_W-1:0];
        end
    end

    assign prdata = (paddr[srbme_pkg::APB_AW-1:2] == srbme_pkg::REG_BLOCK_COUNT)
                    ? 32'(block_count_reg) : '0;

    // front: accept, table read, checks
    srbme_front #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .MASK_BITS  (MASK_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .block_count (block_count_reg),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_full      (q_full)
    );

    // command queue decouples the two halves
    srbme_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // back: record merging, counters, output register
    srbme_back #(
        .MASK_BITS (MASK_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb - sparse row block mask encoder testbench
// Drives load, entry, row end and stream end items into the encoder, keeps
// its own running copy of the width table, open record, counters and error
// flag, and checks every result item field by field, in order, against what
// that copy predicts. Both channels idle and stall at random; block_count is
// rewritten over APB between phases while the encoder is idle.
// ---------------------------------------------------------------------------
module tb;

    // Predicts the result items of every accepted item and holds them
    // until the encoder hands them over.
    class encoder_scoreboard;
        logic [srbme_pkg::WID_W-1:0]  width_tbl [1024];
        logic [srbme_pkg::BCNT_W-1:0] blk_count;
        bit                           open_valid;
        logic [srbme_pkg::BLK_W-1:0]  open_blk;
        logic [31:0]                  open_mask;
        logic [31:0]                  open_start;
        logic [31:0]                  entry_cnt;
        logic [31:0]                  record_cnt;
        bit                           key_valid;
        logic [srbme_pkg::KEY_W-1:0]  last_key;
        bit                           err_flag;
        srbme_pkg::out_t              pending [$];
        int                           fails;

        function new();
            foreach (width_tbl[i]) width_tbl[i] = '0;
            blk_count  = srbme_pkg::BLOCK_COUNT_RESET;
            open_valid = 0;
            open_blk   = '0;
            open_mask  = '0;
            open_start = '0;
            entry_cnt  = '0;
            record_cnt = '0;
            key_valid  = 0;
            last_key   = '0;
            err_flag   = 0;
            fails      = 0;
        endfunction

        function void add_result(srbme_pkg::kind_t k, logic [srbme_pkg::BLK_W-1:0] b,
                                 logic [31:0] m, logic [31:0] v, logic [31:0] r,
                                 logic [1:0] e);
            srbme_pkg::out_t res;
            res.kind         = k;
            res.rec_block    = b;
            res.gene_mask    = m;
            res.value_offset = v;
            res.record_index = r;
            res.error_code   = e;
            res.error_seen   = err_flag;
            res.last         = 1'b0;
            pending.push_back(res);
        endfunction

        // emit the open record, if any; record_index is the count before it
        function void close_record();
            if (!open_valid)
                return;
            add_result(srbme_pkg::KIND_RECORD, open_blk, open_mask, open_start,
                       record_cnt, '0);
            if (record_cnt != '1)
                record_cnt++;
            open_valid = 0;
            open_mask  = '0;
        endfunction

        function void reject(logic [srbme_pkg::BLK_W-1:0] b, srbme_pkg::err_code_t e);
            err_flag = 1;
            add_result(srbme_pkg::KIND_ERROR, b, '0, '0, '0, e);
        endfunction

        function void note_item(srbme_pkg::in_t it);
            logic [srbme_pkg::KEY_W-1:0] key;
            int                          first;
            srbme_pkg::out_t             tail;
            first = pending.size();
            key   = {it.block_id, it.local_id};
            case (it.mode)
                srbme_pkg::MODE_LOAD: begin
                    width_tbl[it.block_id] = it.tbl_width;
                end
                srbme_pkg::MODE_ENTRY: begin
                    // checks in priority order: range, width, key order
                    if (srbme_pkg::BCNT_W'(it.block_id) >= blk_count)
                        reject(it.block_id, srbme_pkg::ERR_RANGE);
                    else if (srbme_pkg::WID_W'(it.local_id) >= width_tbl[it.block_id])
                        reject(it.block_id, srbme_pkg::ERR_WIDTH);
                    else if (key_valid && key <= last_key)
                        reject(it.block_id, srbme_pkg::ERR_ORDER);
                    else begin
                        if (open_valid && open_blk != it.block_id)
                            close_record();
                        if (!open_valid) begin
                            open_valid = 1;
                            open_blk   = it.block_id;
                            open_mask  = '0;
                            open_start = entry_cnt;
                        end
                        open_mask = open_mask | (32'd1 << it.local_id);
                        if (entry_cnt != '1)
                            entry_cnt++;
                        last_key  = key;
                        key_valid = 1;
                    end
                end
                srbme_pkg::MODE_ROW_END: begin
                    close_record();
                    add_result(srbme_pkg::KIND_ROW_END, '0, '0, '0, record_cnt, '0);
                    key_valid = 0;
                    last_key  = '0;
                end
                default: begin
                    // error_seen on the totals is the flag before clearing
                    close_record();
                    add_result(srbme_pkg::KIND_TOTALS, '0, '0, entry_cnt, record_cnt, '0);
                    open_valid = 0;
                    open_blk   = '0;
                    open_mask  = '0;
                    open_start = '0;
                    entry_cnt  = '0;
                    record_cnt = '0;
                    key_valid  = 0;
                    last_key   = '0;
                    err_flag   = 0;
                end
            endcase
            if (pending.size() > first) begin
                tail      = pending.pop_back();
                tail.last = 1'b1;
                pending.push_back(tail);
            end
        endfunction

        task report_mismatch(string msg);
            fails++;
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
        endtask

        task check_result(srbme_pkg::out_t got);
            srbme_pkg::out_t want;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result item, kind %0d", got.kind));
                return;
            end
            want = pending.pop_front();
            check_field("kind",         32'(got.kind),         32'(want.kind));
            check_field("rec_block",    32'(got.rec_block),    32'(want.rec_block));
            check_field("gene_mask",    got.gene_mask,         want.gene_mask);
            check_field("value_offset", got.value_offset,      want.value_offset);
            check_field("record_index", got.record_index,      want.record_index);
            check_field("error_code",   32'(got.error_code),   32'(want.error_code));
            check_field("error_seen",   32'(got.error_seen),   32'(want.error_seen));
            check_field("last",         32'(got.last),         32'(want.last));
        endtask
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    srbme_pkg::in_t               s_data;
    logic                         m_valid;
    logic                         m_ready;
    srbme_pkg::out_t              m_data;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [srbme_pkg::APB_AW-1:0] paddr;
    logic [31:0]                  pwdata;
    logic [31:0]                  prdata;
    logic                         pready;

    encoder_scoreboard            sb;

    // stimulus bookkeeping: only blocks whose width was loaded get entries
    bit                           loaded [1024];
    logic [srbme_pkg::BLK_W-1:0]  loaded_ids [$];
    int unsigned                  items_sent;
    bit                           no_idle;
    bit                           hold_req;
    int                           hold_left;

    sparse_row_block_mask_encoder_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // idle with a probability of 36 percent, unless an idle-free stretch is on
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(0, 99) < 36);
    endfunction

    // ------------------------------------------------------------------
    // Sender side. An item's valid stays high after acceptance until the
    // next task drives it, so every caller that stops sending lowers it
    // first, in the step of the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_item(input srbme_pkg::in_t it);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic load_width(input logic [srbme_pkg::BLK_W-1:0] b,
                              input logic [srbme_pkg::WID_W-1:0] w);
        send_item('{mode: srbme_pkg::MODE_LOAD, block_id: b,
                    local_id: srbme_pkg::LOC_W'($urandom_range(0, 31)), tbl_width: w});
        if (!loaded[b]) begin
            loaded[b] = 1;
            loaded_ids.push_back(b);
        end
    endtask

    task automatic send_entry(input logic [srbme_pkg::BLK_W-1:0] b,
                              input logic [srbme_pkg::LOC_W-1:0] l);
        send_item('{mode: srbme_pkg::MODE_ENTRY, block_id: b, local_id: l,
                    tbl_width: srbme_pkg::WID_W'($urandom_range(0, 63))});
    endtask

    // row end or stream end; the unused fields carry noise
    task automatic send_mark(input srbme_pkg::mode_t m);
        send_item('{mode: m, block_id: srbme_pkg::BLK_W'($urandom_range(0, 1023)),
                    local_id: srbme_pkg::LOC_W'($urandom_range(0, 31)),
                    tbl_width: srbme_pkg::WID_W'($urandom_range(0, 63))});
    endtask

    // Sender stops, waits for every predicted result, then lets the
    // two-stage pipeline and the queue settle before anything else.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Configuration port: setup then access, pready is always high.
    // ------------------------------------------------------------------
    task automatic set_block_count(input int unsigned cnt);
        logic [srbme_pkg::APB_AW-1:0] addr;
        addr    = srbme_pkg::APB_AW'(srbme_pkg::REG_BLOCK_COUNT) << 2;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(cnt);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        sb.blk_count = srbme_pkg::BCNT_W'(cnt);
        // read back through the same port
        pwrite  <= 1'b0;
        penable <= 1'b0;
        pwdata  <= '0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata[srbme_pkg::BCNT_W-1:0] !== srbme_pkg::BCNT_W'(cnt))
            sb.report_mismatch($sformatf("block_count read %h, written %h",
                                         prdata, cnt));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Well-formed row: a few in-range blocks with loaded, non-zero width,
    // several local ids each, sent in strictly rising key order, then
    // closed by a row end or a stream end.
    // ------------------------------------------------------------------
    task automatic send_row(input bit close_stream);
        int                          keys [$];
        int                          nblk;
        int                          nloc;
        int                          w;
        int                          prev;
        logic [srbme_pkg::BLK_W-1:0] b;
        nblk = $urandom_range(0, 3);
        for (int i = 0; i < nblk; i++) begin
            b = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
            if (srbme_pkg::BCNT_W'(b) < sb.blk_count && sb.width_tbl[b] != 0) begin
                w    = (sb.width_tbl[b] > 32) ? 32 : int'(sb.width_tbl[b]);
                nloc = $urandom_range(1, 6);
                repeat (nloc) keys.push_back(int'(b) * 32 + $urandom_range(0, w - 1));
            end
        end
        keys.sort();
        prev = -1;
        foreach (keys[i]) begin
            if (keys[i] != prev)
                send_entry(srbme_pkg::BLK_W'(keys[i] >> 5), srbme_pkg::LOC_W'(keys[i]));
            prev = keys[i];
        end
        send_mark(close_stream ? srbme_pkg::MODE_STREAM_END : srbme_pkg::MODE_ROW_END);
    endtask

    task automatic random_step(input bit pause_on_stream);
        int                          pick;
        logic [srbme_pkg::BLK_W-1:0] b;
        logic [srbme_pkg::WID_W-1:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            if ($urandom_range(0, 4) == 0) begin
                send_row(1'b1);
                if (pause_on_stream && $urandom_range(0, 1) == 0)
                    wait_drained();
            end else
                send_row(1'b0);
        end else if (pick < 75) begin
            b = srbme_pkg::BLK_W'($urandom_range(0, 1023));
            w = srbme_pkg::WID_W'($urandom_range(0, 63));
            // keep block 0 usable so a block_count of 1 still gets records
            if (b == 0 && w == 0)
                w = 6'd32;
            load_width(b, w);
        end else if (pick < 92) begin
            // loose entry: may merge, flush, or fail any of the checks
            send_entry(loaded_ids[$urandom_range(0, loaded_ids.size() - 1)],
                       srbme_pkg::LOC_W'($urandom_range(0, 31)));
        end else if (pick < 97)
            send_mark(srbme_pkg::MODE_ROW_END);
        else
            send_mark(srbme_pkg::MODE_STREAM_END);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, plus one long hold-off on request so
    // the queue fills and s_ready drops while items keep coming.
    // ------------------------------------------------------------------
    initial begin
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_data);
            if (hold_req) begin
                hold_req  = 0;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else
                m_ready <= !idle_now();
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned phase_count [5];
        int unsigned target;

        sb         = new();
        items_sent = 0;
        no_idle    = 0;
        hold_req   = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, block_count at its reset value of 1. Widths cover zero,
        // one, the mask size and values above it.
        load_width(10'd0, 6'd32);
        load_width(10'd1, 6'd1);
        load_width(10'd2, 6'd0);
        load_width(10'd3, 6'd63);
        load_width(10'd5, 6'd33);
        load_width(10'd1023, 6'd17);
        load_width(10'd512, 6'd8);
        send_entry(10'd0, 5'd0);
        send_entry(10'd0, 5'd31);                  // merges into the open record
        send_entry(10'd1, 5'd0);                   // block out of range
        send_mark(srbme_pkg::MODE_ROW_END);        // record then count
        send_mark(srbme_pkg::MODE_ROW_END);        // empty row: count only
        send_entry(10'd0, 5'd5);
        send_entry(10'd0, 5'd5);                   // repeated key
        send_mark(srbme_pkg::MODE_STREAM_END);     // record, totals, sticky flag seen
        send_mark(srbme_pkg::MODE_STREAM_END);     // empty stream, flag now clear
        wait_drained();

        set_block_count(1024);
        send_entry(10'd2, 5'd0);            // zero width rejects everything
        send_entry(10'd1, 5'd1);            // local at the width
        send_entry(10'd1, 5'd0);
        send_entry(10'd3, 5'd31);           // width above the mask size
        send_entry(10'd5, 5'd31);
        send_entry(10'd1023, 5'd16);
        send_entry(10'd1023, 5'd17);        // local out of width
        send_entry(10'd512, 5'd3);          // key below the previous one
        send_mark(srbme_pkg::MODE_ROW_END);
        send_mark(srbme_pkg::MODE_STREAM_END);
        wait_drained();

        // Random phases across block_count settings, extremes included
        phase_count = '{1, $urandom_range(3, 1023), 1024, 2, 1024};
        for (int p = 0; p < 5; p++) begin
            set_block_count(phase_count[p]);
            no_idle = (p == 2);
            if (p == 4)
                hold_req = 1;
            target = items_sent + 200;
            while (items_sent < target)
                random_step(p == 1);
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // guard against a hung handshake: far beyond the slowest correct run
    initial begin
        #(200_000 * 12);
        $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/srbme_pkg.sv
hdl/srbme_front.sv
hdl/srbme_fifo.sv
hdl/srbme_back.sv
hdl/sparse_row_block_mask_encoder_unit.sv
tb/tb.sv
